// File: hdl/dnsd_pkg.sv
// shared types and constants for the dns name decompressor
`default_nettype none

package dnsd_pkg;

    // walk position and pointer target width, and width for offset compares
    localparam int POS_W = 14;
    localparam int CMP_W = 15;
    localparam int LEN_W = 13;

    localparam logic [7:0] PTR_MASK  = 8'hC0;
    localparam logic [7:0] MAX_LABEL = 8'd63;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_NEXT  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_PAST_END  = 3'd1,
        ERR_PTR_TRUNC = 3'd2,
        ERR_CYCLE     = 3'd3,
        ERR_HOPS      = 3'd4,
        ERR_BAD_LEN   = 3'd5,
        ERR_OVERRUN   = 3'd6,
        ERR_NO_WALK   = 3'd7
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BYTE,
        ST_PTR
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic rd_cur;
        logic rd_next;
        logic follow;
        logic emit_label;
        logic emit_root;
        logic emit_fail;
        t_err err;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic past_end;
        logic is_ptr;
        logic ptr_trunc;
        logic is_root;
        logic bad_len;
        logic overrun;
        logic cycle_hit;
        logic hops_full;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/dnsd_ctrl.sv
// walk controller: sequences reads, pointer hops and result requests
`default_nettype none

module dnsd_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire  [1:0]          i_req_type,
    output logic                o_in_stall,
    input  wire dnsd_pkg::t_stat i_stat,
    output dnsd_pkg::t_cmd      o_cmd
);

    dnsd_pkg::t_state r_state;
    dnsd_pkg::t_state n_state;
    logic             w_accept;
    dnsd_pkg::t_req   w_req;

    assign o_in_stall = (r_state != dnsd_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_req      = dnsd_pkg::t_req'(i_req_type);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnsd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.err = dnsd_pkg::ERR_OK;
        unique case (r_state)
            dnsd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_req)
                        dnsd_pkg::REQ_LOAD:  o_cmd.load  = 1'b1;
                        dnsd_pkg::REQ_START: o_cmd.start = 1'b1;
                        dnsd_pkg::REQ_NEXT:  n_state     = dnsd_pkg::ST_CHECK;
                        dnsd_pkg::REQ_NOP:   n_state     = dnsd_pkg::ST_IDLE;
                        default:             n_state     = dnsd_pkg::ST_IDLE;
                    endcase
                end
            end
            dnsd_pkg::ST_CHECK: begin
                priority if (!i_stat.active || i_stat.past_end) begin
                    // results wait here until the output register has room
                    if (i_stat.out_free) begin
                        o_cmd.emit_fail = 1'b1;
                        o_cmd.err = !i_stat.active ? dnsd_pkg::ERR_NO_WALK
                                                   : dnsd_pkg::ERR_PAST_END;
                        n_state = dnsd_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state = dnsd_pkg::ST_BYTE;
                end
            end
            dnsd_pkg::ST_BYTE: begin
                if (i_stat.is_ptr && !i_stat.ptr_trunc) begin
                    o_cmd.rd_next = 1'b1;
                    n_state = dnsd_pkg::ST_PTR;
                end else if (i_stat.out_free) begin
                    n_state = dnsd_pkg::ST_IDLE;
                    priority if (i_stat.is_ptr) begin
                        o_cmd.emit_fail = 1'b1;
                        o_cmd.err = dnsd_pkg::ERR_PTR_TRUNC;
                    end else if (i_stat.is_root) begin
                        o_cmd.emit_root = 1'b1;
                    end else if (i_stat.bad_len) begin
                        o_cmd.emit_fail = 1'b1;
                        o_cmd.err = dnsd_pkg::ERR_BAD_LEN;
                    end else if (i_stat.overrun) begin
                        o_cmd.emit_fail = 1'b1;
                        o_cmd.err = dnsd_pkg::ERR_OVERRUN;
                    end else begin
                        o_cmd.emit_label = 1'b1;
                    end
                end
            end
            dnsd_pkg::ST_PTR: begin
                priority if (i_stat.cycle_hit || i_stat.hops_full) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_fail = 1'b1;
                        o_cmd.err = i_stat.cycle_hit ? dnsd_pkg::ERR_CYCLE
                                                     : dnsd_pkg::ERR_HOPS;
                        n_state = dnsd_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.follow = 1'b1;
                    n_state = dnsd_pkg::ST_CHECK;
                end
            end
            default: n_state = dnsd_pkg::ST_IDLE;
        endcase
    end

    // a walk step never starts outside a next request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dnsd_pkg::ST_IDLE && n_state == dnsd_pkg::ST_CHECK)
            |-> (w_accept && w_req == dnsd_pkg::REQ_NEXT))
        else $error("walk began without a next request");

    // a pointer decode always follows a second-byte read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dnsd_pkg::ST_PTR && $past(r_state) != dnsd_pkg::ST_PTR)
            |-> $past(o_cmd.rd_next))
        else $error("pointer decode without second byte read");

    // results leave the walk states only back to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_fail || o_cmd.emit_root || o_cmd.emit_label)
            |=> (r_state == dnsd_pkg::ST_IDLE))
        else $error("result emitted but walk did not end");

endmodule

`default_nettype wire

// File: hdl/dnsd_datapath.sv
// datapath: message store, walk registers, pointer history and output register
`default_nettype none

module dnsd_datapath #(
    parameter int BUF_DEPTH = 4096,
    parameter int MAX_HOPS  = 7
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire  [dnsd_pkg::LEN_W-1:0]   i_cfg_msg_length,
    input  wire  [11:0]                  i_address,
    input  wire  [7:0]                   i_data_byte,
    input  wire dnsd_pkg::t_cmd          i_cmd,
    output dnsd_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [11:0]                  o_label_start,
    output logic [5:0]                   o_label_len,
    output logic                         o_name_done,
    output logic [dnsd_pkg::LEN_W-1:0]   o_end_offset,
    output logic [2:0]                   o_error_code
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int HW = $clog2(MAX_HOPS + 1);
    localparam logic [dnsd_pkg::CMP_W-1:0] DEPTH_C = dnsd_pkg::CMP_W'(BUF_DEPTH);

    logic [7:0]                  r_mem [BUF_DEPTH];
    logic [7:0]                  r_rdata;
    logic [7:0]                  r_byte0;
    logic [dnsd_pkg::LEN_W-1:0]  r_msg_length;
    logic [dnsd_pkg::POS_W-1:0]  r_cur;
    logic                        r_active;
    logic                        r_jumped;
    logic [HW-1:0]               r_hop;
    logic [dnsd_pkg::POS_W-1:0]  r_visited [MAX_HOPS];
    logic [dnsd_pkg::LEN_W-1:0]  r_saved;

    logic [dnsd_pkg::CMP_W-1:0]  w_len;
    logic [dnsd_pkg::CMP_W-1:0]  w_cur;
    logic [dnsd_pkg::CMP_W-1:0]  w_cur_p1;
    logic [dnsd_pkg::CMP_W-1:0]  w_label_end;
    logic [dnsd_pkg::CMP_W-1:0]  w_waddr;
    logic [dnsd_pkg::CMP_W-1:0]  w_raddr;
    logic [dnsd_pkg::POS_W-1:0]  w_target;
    logic                        w_hit;
    logic                        w_emit;

    assign w_len = ({2'b00, r_msg_length} > DEPTH_C) ? DEPTH_C : {2'b00, r_msg_length};
    assign w_cur       = {1'b0, r_cur};
    assign w_cur_p1    = w_cur + dnsd_pkg::CMP_W'(1);
    assign w_label_end = w_cur_p1 + {{(dnsd_pkg::CMP_W-8){1'b0}}, r_rdata};
    assign w_waddr     = dnsd_pkg::CMP_W'(i_address);
    assign w_raddr     = i_cmd.rd_next ? w_cur_p1 : w_cur;
    assign w_target    = {r_byte0[5:0], r_rdata};
    assign w_emit      = i_cmd.emit_label || i_cmd.emit_root || i_cmd.emit_fail;

    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < MAX_HOPS; i++) begin
            if ((HW'(i) < r_hop) && (r_visited[i] == w_target)) begin
                w_hit = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.active    = r_active;
        o_stat.past_end  = (w_cur >= w_len);
        o_stat.is_ptr    = ((r_rdata & dnsd_pkg::PTR_MASK) == dnsd_pkg::PTR_MASK);
        o_stat.ptr_trunc = ((w_cur + dnsd_pkg::CMP_W'(2)) > w_len);
        o_stat.is_root   = (r_rdata == 8'd0);
        o_stat.bad_len   = (r_rdata > dnsd_pkg::MAX_LABEL);
        o_stat.overrun   = (w_label_end > w_len);
        o_stat.cycle_hit = w_hit;
        o_stat.hops_full = (r_hop >= HW'(MAX_HOPS));
        o_stat.out_free  = !o_out_valid || !i_out_stall;
    end

    // message store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (w_waddr < DEPTH_C)) begin
            r_mem[w_waddr[AW-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd_cur || i_cmd.rd_next) begin
            r_rdata <= r_mem[w_raddr[AW-1:0]];
        end
        if (i_cmd.rd_next) begin
            r_byte0 <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.follow) begin
            for (int i = 0; i < MAX_HOPS; i++) begin
                if (r_hop == HW'(i)) begin
                    r_visited[i] <= w_target;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_length <= '0;
            r_cur        <= '0;
            r_active     <= 1'b0;
            r_jumped     <= 1'b0;
            r_hop        <= '0;
            r_saved      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_msg_length <= i_cfg_msg_length;
            end
            if (i_cmd.start) begin
                r_cur    <= dnsd_pkg::POS_W'(i_address);
                r_active <= 1'b1;
                r_jumped <= 1'b0;
                r_hop    <= '0;
                r_saved  <= '0;
            end
            if (i_cmd.follow) begin
                r_hop <= r_hop + HW'(1);
                r_cur <= w_target;
                // the name ends in place right after the first pointer
                if (!r_jumped) begin
                    r_saved  <= dnsd_pkg::LEN_W'(w_cur + dnsd_pkg::CMP_W'(2));
                    r_jumped <= 1'b1;
                end
            end
            if (i_cmd.emit_label) begin
                r_cur <= dnsd_pkg::POS_W'(w_label_end);
            end
            if (i_cmd.emit_root || i_cmd.emit_fail) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_label_start <= i_cmd.emit_label ? w_cur_p1[11:0] : 12'd0;
            o_label_len   <= i_cmd.emit_label ? r_rdata[5:0] : 6'd0;
            o_name_done   <= !i_cmd.emit_label;
            o_error_code  <= i_cmd.emit_fail ? i_cmd.err : dnsd_pkg::ERR_OK;
            if (i_cmd.emit_root) begin
                o_end_offset <= r_jumped ? r_saved : dnsd_pkg::LEN_W'(w_cur_p1);
            end else begin
                o_end_offset <= '0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hop <= HW'(MAX_HOPS))
        else $error("hop count beyond limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.emit_label, i_cmd.emit_root, i_cmd.emit_fail}))
        else $error("more than one result kind at once");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrote a waiting result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_fail |=> (!r_active && o_out_valid && o_name_done))
        else $error("error did not end the walk");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.follow |-> (r_active && !w_hit && (r_hop < HW'(MAX_HOPS))))
        else $error("pointer followed past a cycle or hop limit");

endmodule

`default_nettype wire

// File: hdl/dns_name_decompressor_core.sv
// top level of the dns name decompressor
`default_nettype none

// Walks DNS names in a loaded message one label per next request, following
// compression pointers. A next request reads the length byte with one
// registered read of the message store, and for every pointer it follows, a
// second read for the pointer's low byte. Requests are taken one at a time,
// and the next one is taken while a finished result still waits in the
// output register.
module dns_name_decompressor_core #(
    parameter int BUF_DEPTH = 4096,
    parameter int MAX_HOPS  = 7
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [12:0] i_cfg_msg_length,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_req_type,
    input  wire  [11:0] i_address,
    input  wire  [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [11:0] o_label_start,
    output logic [5:0]  o_label_len,
    output logic        o_name_done,
    output logic [12:0] o_end_offset,
    output logic [2:0]  o_error_code
);

    dnsd_pkg::t_cmd  w_cmd;
    dnsd_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    dnsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dnsd_datapath #(
        .BUF_DEPTH (BUF_DEPTH),
        .MAX_HOPS  (MAX_HOPS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_msg_length (i_cfg_msg_length),
        .i_address        (i_address),
        .i_data_byte      (i_data_byte),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_label_start    (o_label_start),
        .o_label_len      (o_label_len),
        .o_name_done      (o_name_done),
        .o_end_offset     (o_end_offset),
        .o_error_code     (o_error_code)
    );

endmodule

`default_nettype wire
